/* rtl/sbc_pkg.sv */
package sbc_pkg;

  localparam int unsigned SumW   = 32;
  localparam int unsigned WordW  = 24;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [7:0] PadReset = 8'h58;

  typedef enum logic [1:0] {
    MODE_8  = 2'd0,
    MODE_16 = 2'd1,
    MODE_32 = 2'd2,
    MODE_32B = 2'd3
  } mode_t;

  // register select is bit 2 of the byte address
  typedef enum logic {
    REG_MODE = 1'b0,
    REG_PAD  = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2,
    PH_3 = 2'd3
  } phase_t;

  // 32-bit add with end-around carry
  function automatic logic [SumW-1:0] add_fold32(input logic [SumW-1:0] a,
                                                 input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
  endfunction

endpackage

/* rtl/selectable_width_byte_checksum_core.sv */
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_data_byte, in_last_byte
// out     | output    | out_valid/out_stall | out_checksum, out_pad_count
// cfg     | input     | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// one byte beat per cycle while in_stall is low; each byte folds into the sum or the open word in the cycle it is taken
// the result beat is registered and shows in the cycle after the last byte is taken
// a last byte waits only while a result beat is stalled; other bytes never wait
// reset clears the sum, the open word and the phase; mode 8-bit, pad byte 0x58
module selectable_width_byte_checksum_core import sbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_checksum,
  output logic [1:0]           out_pad_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  logic [1:0]       mode_r;
  logic [7:0]       pad_r;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [WordW-1:0] word_r, word_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      res_r, res_nxt;
  logic [1:0]       pads_r, pads_nxt;
  logic             in_acc;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_sel_t'(paddr[2]))
      REG_MODE: prdata = {30'd0, mode_r};
      REG_PAD:  prdata = {24'd0, pad_r};
      default:  prdata = '0;
    endcase
  end

  assign in_stall = out_valid_r & out_stall & in_last_byte;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    logic [WordW-1:0] word_or;
    logic [SumW-1:0]  s1;
    logic [SumW-1:0]  padword;
    logic [16:0]      s16;
    logic [15:0]      w16;
    sum_nxt   = sum_r;
    word_nxt  = word_r;
    phase_nxt = phase_r;
    pads_nxt  = 2'd0;
    res_nxt   = sum_r;
    word_or   = word_r;
    s1        = '0;
    padword   = '0;
    s16       = '0;
    w16       = '0;
    if (mode_r[1]) begin
      case (phase_t'(phase_r))
        PH_0:    word_or = word_r | {in_data_byte, 16'd0};
        PH_1:    word_or = word_r | {8'd0, in_data_byte, 8'd0};
        default: word_or = word_r | {16'd0, in_data_byte};
      endcase
      case (phase_t'(phase_r))
        PH_0:    padword = {8'd0, pad_r, pad_r, pad_r};
        PH_1:    padword = {16'd0, pad_r, pad_r};
        default: padword = {24'd0, pad_r};
      endcase
      if (phase_r == PH_3) begin
        sum_nxt   = add_fold32(sum_r, {word_r, in_data_byte});
        word_nxt  = '0;
        phase_nxt = PH_0;
      end else begin
        word_nxt  = word_or;
        phase_nxt = phase_r + 2'd1;
        if (in_last_byte) begin
          // open word goes in with zero low bytes, then the pad bytes
          s1       = add_fold32(sum_r, {word_or, 8'd0});
          sum_nxt  = add_fold32(s1, padword);
          pads_nxt = 2'd3 - phase_r;
        end
      end
      res_nxt = sum_nxt;
    end else if (mode_r == MODE_16) begin
      if (phase_r != PH_0) begin
        w16       = sum_r[15:0] + {word_r[23:16], in_data_byte};
        sum_nxt   = {16'd0, w16};
        word_nxt  = '0;
        phase_nxt = PH_0;
      end else if (in_last_byte) begin
        s16      = {1'b0, sum_r[15:0]} + {1'b0, in_data_byte, pad_r};
        w16      = s16[15:0] + {15'd0, s16[16]};
        sum_nxt  = {16'd0, w16};
        pads_nxt = 2'd1;
      end else begin
        word_nxt  = {in_data_byte, 16'd0};
        phase_nxt = PH_1;
      end
      res_nxt = {16'd0, sum_nxt[15:0]};
    end else begin
      sum_nxt = {24'd0, sum_r[7:0] + in_data_byte};
      res_nxt = sum_nxt;
    end
    if (in_last_byte) begin
      sum_nxt   = '0;
      word_nxt  = '0;
      phase_nxt = PH_0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_8;
      pad_r       <= PadReset;
      sum_r       <= '0;
      word_r      <= '0;
      phase_r     <= PH_0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_sel_t'(paddr[2]))
          REG_MODE: mode_r <= pwdata[1:0];
          REG_PAD:  pad_r  <= pwdata[7:0];
          default:  ;
        endcase
      end
      if (in_acc) begin
        sum_r   <= sum_nxt;
        word_r  <= word_nxt;
        phase_r <= phase_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      res_r  <= res_nxt;
      pads_r <= pads_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_checksum  = res_r;
  assign out_pad_count = pads_r;

  a_mid_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_byte && !out_valid_r) |=> !out_valid)
    else $error("non-final byte raised a result beat");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (sum_r == '0 && word_r == '0 && phase_r == PH_0))
    else $error("state not cleared after final byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_r) && $stable(pads_r)))
    else $error("stalled result beat overwritten");

  a_pad_mode8: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte && mode_r == MODE_8) |=> (pads_r == 2'd0 && res_r[31:8] == '0))
    else $error("8-bit mode result out of range");

endmodule

/* sim/tb_selectable_width_byte_checksum_core.sv */
module tb_selectable_width_byte_checksum_core;
  import sbc_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned SettleCycles = 3;

  typedef struct {
    logic [31:0] checksum;
    logic [1:0]  pad_count;
  } csum_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = '0;
  logic             in_last_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      out_checksum;
  logic [1:0]       out_pad_count;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // predictor state and register copies
  mode_t       cfg_mode = MODE_8;
  logic [7:0]  cfg_pad = PadReset;
  logic [31:0] sum_acc = '0;
  logic [23:0] open_word = '0;
  logic [1:0]  open_bytes = '0;

  csum_result_t expected_sums[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  quiet_cycles = 0;

  selectable_width_byte_checksum_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum),
    .out_pad_count(out_pad_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] add_end_around(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + {31'd0, s[32]};
  endfunction

  // folds one byte into the running checksum; hit is set on the last byte of a message
  task automatic accumulate_byte(input logic [7:0] b, input logic last, output bit hit,
                                 output csum_result_t res);
    logic [1:0]  pads;
    logic [31:0] pad_word;
    logic [16:0] s17;
    int          sh;
    int          k;
    pads = 2'd0;
    if (cfg_mode[1]) begin
      if (open_bytes == 2'd3) begin
        sum_acc = add_end_around(sum_acc, {open_word, b});
        open_word = '0;
        open_bytes = 2'd0;
      end else begin
        sh = 16 - 8 * int'(open_bytes);
        open_word = open_word | (24'(b) << sh);
        if (last) begin
          pads = 2'd3 - open_bytes;
          sum_acc = add_end_around(sum_acc, {open_word, 8'h00});
          pad_word = '0;
          for (k = 0; k < int'(pads); k++) pad_word = pad_word | (32'(cfg_pad) << (8 * k));
          sum_acc = add_end_around(sum_acc, pad_word);
        end
        open_bytes = open_bytes + 2'd1;
      end
      res.checksum = sum_acc;
    end else if (cfg_mode == MODE_16) begin
      if (open_bytes != 2'd0) begin
        sum_acc = {16'd0, sum_acc[15:0] + {open_word[23:16], b}};
        open_word = '0;
        open_bytes = 2'd0;
      end else if (last) begin
        // odd final byte: pad fills the low half, one carry fold
        s17 = {1'b0, sum_acc[15:0]} + {1'b0, b, cfg_pad};
        sum_acc = {16'd0, s17[15:0] + {15'd0, s17[16]}};
        pads = 2'd1;
      end else begin
        open_word = {b, 16'd0};
        open_bytes = 2'd1;
      end
      res.checksum = {16'd0, sum_acc[15:0]};
    end else begin
      sum_acc = {24'd0, sum_acc[7:0] + b};
      res.checksum = sum_acc;
    end
    res.pad_count = pads;
    hit = last;
    if (last) begin
      sum_acc = '0;
      open_word = '0;
      open_bytes = 2'd0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    bit           hit;
    csum_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    accumulate_byte(b, last, hit, res);
    if (hit) expected_sums.push_back(res);
  endtask

  // sender pauses until every checksum beat is out and the core has gone quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_sel_t sel, input logic [31:0] value);
    logic [7:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({sel, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_MODE) cfg_mode = mode_t'(value[1:0]);
    else cfg_pad = value[7:0];
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (sel == REG_MODE) ? {6'd0, cfg_mode} : cfg_pad;
    if (sel == REG_MODE && prdata[1:0] != want[1:0])
      report_mismatch("mode readback", {30'd0, prdata[1:0]}, {24'd0, want});
    else if (sel == REG_PAD && prdata[7:0] != want)
      report_mismatch("pad readback", {24'd0, prdata[7:0]}, {24'd0, want});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input mode_t mode, input logic [7:0] pad);
    settle_block();
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_PAD, 32'(pad));
  endtask

  task automatic test_byte_mode();
    configure(MODE_8, 8'h00);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_word16_mode();
    configure(MODE_16, 8'hFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    configure(MODE_16, 8'h00);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  task automatic test_word32_mode();
    int i;
    configure(MODE_32, 8'hFF);
    send_byte(8'hFF, 1'b1);
    for (i = 0; i < 5; i++) send_byte((i == 4) ? 8'h80 : 8'hFF, i == 4);
    // mode value 3 behaves as 32-bit; full final word needs no pad
    configure(MODE_32B, 8'h00);
    for (i = 0; i < 4; i++) send_byte(8'hF0 | 8'(i), i == 3);
  endtask

  task automatic test_mode_switch_midmessage();
    configure(MODE_32, 8'h58);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    settle_block();
    write_reg(REG_MODE, 32'(MODE_8));
    send_byte(8'h01, 1'b0);
    settle_block();
    write_reg(REG_MODE, 32'(MODE_16));
    send_byte(8'h02, 1'b1);
  endtask

  function automatic logic [7:0] pick_pad();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_random_traffic(input int n_bytes, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int sent;
    int len;
    int split;
    int i;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(2) == 0) configure(mode_t'($urandom_range(3)), pick_pad());
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      // now and then the mode changes partway through a message
      split = (len > 1 && $urandom_range(7) == 0) ? $urandom_range(0, len - 2) : -1;
      for (i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1);
        sent++;
        if (i == split) begin
          settle_block();
          write_reg(REG_MODE, 32'($urandom_range(3)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    csum_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected checksum beat", out_checksum, 32'd0);
      end else begin
        want = expected_sums.pop_front();
        if (out_checksum !== want.checksum)
          report_mismatch("checksum", out_checksum, want.checksum);
        if (out_pad_count !== want.pad_count)
          report_mismatch("pad_count", {30'd0, out_pad_count}, {30'd0, want.pad_count});
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_byte_mode();
    test_word16_mode();
    test_word32_mode();
    test_mode_switch_midmessage();
    test_random_traffic(530, 24, 80);
    test_random_traffic(530, 80, 24);
    test_random_traffic(540, 0, 0);
    settle_block();
    repeat (4) @(posedge clk);
    $display("%0d message bytes sent, %0d checksum beats checked", bytes_sent, results_seen);
    $display("covered 8/16/32-bit modes, pad fills, mode changes mid-message, random stalls");
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sbc_pkg.sv
rtl/selectable_width_byte_checksum_core.sv
sim/tb_selectable_width_byte_checksum_core.sv
